### hdl/psg_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// psg_pkg: shared types and constants of the tone/envelope sound generator
// Word layout, register map, envelope shape tables and amplitude curve.
// ---------------------------------------------------------------------------
package psg_pkg;

   localparam int REG_COUNT_N = 14;
   localparam int VOICES      = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] REG_COUNT  = 4'd14;
   localparam logic [3:0] REG_NOISE  = 4'd6;
   localparam logic [3:0] REG_MIXER  = 4'd7;
   localparam logic [3:0] REG_VOL_A  = 4'd8;
   localparam logic [3:0] REG_ENV_LO = 4'd11;
   localparam logic [3:0] REG_ENV_HI = 4'd12;
   localparam logic [3:0] REG_SHAPE  = 4'd13;

   localparam logic [7:0] STEP_RESET = 8'd7;

   // low register of each 16-bit period pair: tone A, B, C, envelope
   localparam logic [3:0] PAIR_LO [0:3] = '{4'd0, 4'd2, 4'd4, 4'd11};

   typedef enum logic [1:0] {
      KIND_TICK  = 2'b01,
      KIND_WRITE = 2'b10
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic [3:0]    index;
      logic [7:0]    value;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      DIR_HOLD = 2'b00,
      DIR_UP   = 2'b01,
      DIR_DOWN = 2'b10
   } env_dir_type;

   localparam env_dir_type ENV_DIR [0:15][0:1] = '{
      '{DIR_DOWN, DIR_HOLD}, '{DIR_DOWN, DIR_HOLD},
      '{DIR_DOWN, DIR_HOLD}, '{DIR_DOWN, DIR_HOLD},
      '{DIR_UP,   DIR_HOLD}, '{DIR_UP,   DIR_HOLD},
      '{DIR_UP,   DIR_HOLD}, '{DIR_UP,   DIR_HOLD},
      '{DIR_DOWN, DIR_DOWN}, '{DIR_DOWN, DIR_HOLD},
      '{DIR_DOWN, DIR_UP},   '{DIR_DOWN, DIR_HOLD},
      '{DIR_UP,   DIR_UP},   '{DIR_UP,   DIR_HOLD},
      '{DIR_UP,   DIR_DOWN}, '{DIR_UP,   DIR_HOLD}
   };

   localparam logic [4:0] ENV_RELOAD [0:15][0:1] = '{
      '{5'd31, 5'd0},  '{5'd31, 5'd0},  '{5'd31, 5'd0},  '{5'd31, 5'd0},
      '{5'd0,  5'd0},  '{5'd0,  5'd0},  '{5'd0,  5'd0},  '{5'd0,  5'd0},
      '{5'd31, 5'd31}, '{5'd31, 5'd0},  '{5'd31, 5'd0},  '{5'd31, 5'd31},
      '{5'd0,  5'd0},  '{5'd0,  5'd31}, '{5'd0,  5'd31}, '{5'd0,  5'd0}
   };

   localparam logic [7:0] AMP_TABLE [0:31] = '{
      8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h04, 8'h05,
      8'h06, 8'h08, 8'h09, 8'h0A, 8'h0C, 8'h0F, 8'h11, 8'h14,
      8'h18, 8'h1C, 8'h21, 8'h26, 8'h2D, 8'h36, 8'h3F, 8'h48,
      8'h55, 8'h66, 8'h77, 8'h88, 8'hA2, 8'hC1, 8'hE0, 8'hFF
   };

endpackage
`default_nettype wire

### hdl/psg_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// psg_front: input stage
// Takes request words, drops writes to unused registers, tags the rest as
// tick or write and hands them to the queue.
// ---------------------------------------------------------------------------
module psg_front (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire  [15:0]                req_tdata,   // [3:0] reg_index, [11:4] reg_value
   input  wire  [0:0]                 req_tuser,   // [0] req_type
   input  wire psg_pkg::queue_status_type q_status,
   output logic                       push,
   output psg_pkg::item_type          push_item
);

   logic              valid_ff, valid_in;
   psg_pkg::item_type item_ff, item_in;
   logic              accept;
   logic              drop;

   assign req_tready = !valid_ff || !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign push       = valid_ff && !q_status.full;
   assign drop       = req_tuser[0] && (req_tdata[3:0] >= psg_pkg::REG_COUNT);
   assign push_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in      = !drop;
         item_in.kind  = req_tuser[0] ? psg_pkg::KIND_WRITE : psg_pkg::KIND_TICK;
         item_in.index = req_tdata[3:0];
         item_in.value = req_tdata[11:4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule
`default_nettype wire

### hdl/psg_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// psg_queue: short item queue
// Decouples the input stage from the execution stage.
// ---------------------------------------------------------------------------
module psg_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  wire psg_pkg::item_type     push_item,
   input  wire                        pop,
   output psg_pkg::item_type          pop_item,
   output psg_pkg::queue_status_type  q_status
);

   localparam logic [psg_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
      psg_pkg::QUEUE_PTR_W'(psg_pkg::QUEUE_DEPTH - 1);
   localparam logic [psg_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
      psg_pkg::QUEUE_CNT_W'(psg_pkg::QUEUE_DEPTH);

   psg_pkg::item_type                 slot_ff [psg_pkg::QUEUE_DEPTH];
   logic [psg_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [psg_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [psg_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;

   assign q_status.full  = (count_ff == CNT_FULL);
   assign q_status.empty = (count_ff == '0);
   assign pop_item       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("queue pop while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

### hdl/psg_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// psg_back: execution stage
// Holds the register file, tone and envelope counters; applies writes,
// steps the counters on ticks and registers the mixed samples.
// ---------------------------------------------------------------------------
module psg_back (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire  [7:0]                 csr_data,
   input  wire psg_pkg::queue_status_type q_status,
   input  wire psg_pkg::item_type     pop_item,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output logic [23:0]                rsp_tdata    // [7:0] a, [15:8] b, [23:16] c
);

   logic [7:0]  step_ff;
   logic [7:0]  regs_ff   [psg_pkg::REG_COUNT_N];
   logic [7:0]  regs_in   [psg_pkg::REG_COUNT_N];
   logic [15:0] tone_ff   [psg_pkg::VOICES];
   logic [15:0] tone_in   [psg_pkg::VOICES];
   logic [15:0] tone_next [psg_pkg::VOICES];
   logic [15:0] tone_diff [psg_pkg::VOICES];
   logic [psg_pkg::VOICES-1:0] tone_hit;
   logic [15:0] env_cnt_ff, env_cnt_in, env_cnt_cur, env_diff, env_next;
   logic        env_hit;
   logic [4:0]  level_ff, level_in, level_cur, level_next;
   logic        seg_ff, seg_in, seg_cur, seg_next;
   logic        restart_ff, restart_in;
   logic [psg_pkg::VOICES-1:0] waves_ff, waves_in, waves_next;
   logic [15:0] step16;
   logic [3:0]  shape;
   logic [7:0]  env_amp;
   logic [7:0]  sample [psg_pkg::VOICES];
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;
   logic        is_tick;
   psg_pkg::env_dir_type dir;

   assign csr_ready  = 1'b1;
   assign pop        = !q_status.empty && (!rsp_valid_ff || rsp_tready);
   assign is_tick    = (pop_item.kind == psg_pkg::KIND_TICK);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign step16      = {8'h00, step_ff};
   assign shape       = regs_ff[psg_pkg::REG_SHAPE][3:0];
   assign env_cnt_cur = restart_ff ? 16'h0000 : env_cnt_ff;
   assign seg_cur     = restart_ff ? 1'b0 : seg_ff;
   assign level_cur   = restart_ff ? psg_pkg::ENV_RELOAD[shape][0] : level_ff;

   for (genvar i = 0; i < psg_pkg::VOICES; i++) begin : g_tone
      logic [15:0] period;
      logic [7:0]  vol;
      assign period       = {regs_ff[2*i+1], regs_ff[2*i]};
      assign tone_diff[i] = tone_ff[i] - step16;
      assign tone_hit[i]  = (tone_diff[i] == 16'h0000) || tone_diff[i][15];
      assign tone_next[i] = tone_hit[i] ? tone_diff[i] + period : tone_diff[i];

      assign vol = regs_ff[psg_pkg::REG_VOL_A + i];
      always_comb begin
         sample[i] = vol[4] ? env_amp : psg_pkg::AMP_TABLE[{vol[3:0], 1'b1}];
         if (!(waves_next[i] || regs_ff[psg_pkg::REG_MIXER][i])) begin
            sample[i] = 8'h00;
         end
      end
   end

   assign waves_next = waves_ff ^ tone_hit;

   assign env_diff = env_cnt_cur - step16;
   assign env_hit  = (env_diff == 16'h0000) || env_diff[15];
   assign env_next = env_hit ?
      env_diff + {regs_ff[psg_pkg::REG_ENV_HI], regs_ff[psg_pkg::REG_ENV_LO]} : env_diff;
   assign dir      = psg_pkg::ENV_DIR[shape][seg_cur];

   always_comb begin
      seg_next   = seg_cur;
      level_next = level_cur;
      if (env_hit) begin
         unique case (dir)
            psg_pkg::DIR_UP: begin
               if (&level_cur) begin
                  seg_next   = !seg_cur;
                  level_next = psg_pkg::ENV_RELOAD[shape][!seg_cur];
               end else begin
                  level_next = level_cur + 5'd1;
               end
            end
            psg_pkg::DIR_DOWN: begin
               if (level_cur == 5'd0) begin
                  seg_next   = !seg_cur;
                  level_next = psg_pkg::ENV_RELOAD[shape][!seg_cur];
               end else begin
                  level_next = level_cur - 5'd1;
               end
            end
            default: begin
               level_next = level_cur;
            end
         endcase
      end
   end

   assign env_amp = psg_pkg::AMP_TABLE[level_next];

   always_comb begin
      regs_in      = regs_ff;
      tone_in      = tone_ff;
      env_cnt_in   = env_cnt_ff;
      level_in     = level_ff;
      seg_in       = seg_ff;
      restart_in   = restart_ff;
      waves_in     = waves_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (pop && is_tick) begin
         tone_in      = tone_next;
         env_cnt_in   = env_next;
         level_in     = level_next;
         seg_in       = seg_next;
         restart_in   = 1'b0;
         waves_in     = waves_next;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {sample[2], sample[1], sample[0]};
      end else if (pop) begin
         regs_in[pop_item.index] = pop_item.value;
         for (int p = 0; p < 4; p++) begin
            if ((pop_item.index == psg_pkg::PAIR_LO[p]) ||
                (pop_item.index == psg_pkg::PAIR_LO[p] + 4'd1)) begin
               if ({regs_in[psg_pkg::PAIR_LO[p] + 4'd1], regs_in[psg_pkg::PAIR_LO[p]]}
                   < step16) begin
                  regs_in[psg_pkg::PAIR_LO[p]]        = step_ff;
                  regs_in[psg_pkg::PAIR_LO[p] + 4'd1] = 8'h00;
               end
            end
         end
         if ((pop_item.index == psg_pkg::REG_NOISE) &&
             (regs_in[psg_pkg::REG_NOISE] < step_ff)) begin
            regs_in[psg_pkg::REG_NOISE] = step_ff;
         end
         if (pop_item.index == psg_pkg::REG_SHAPE) begin
            regs_in[psg_pkg::REG_SHAPE] = {4'h0, pop_item.value[3:0]};
            restart_in                  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= psg_pkg::STEP_RESET;
         regs_ff      <= '{default: '0};
         tone_ff      <= '{default: '0};
         env_cnt_ff   <= '0;
         level_ff     <= '0;
         seg_ff       <= 1'b0;
         restart_ff   <= 1'b0;
         waves_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            step_ff <= csr_data;
         end
         regs_ff      <= regs_in;
         tone_ff      <= tone_in;
         env_cnt_ff   <= env_cnt_in;
         level_ff     <= level_in;
         seg_ff       <= seg_in;
         restart_ff   <= restart_in;
         waves_ff     <= waves_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_restart_cleared: assert property (@(posedge clock) disable iff (reset)
      (pop && is_tick) |=> !restart_ff)
      else $error("envelope restart still pending after a tick");
   a_shape_masked: assert property (@(posedge clock) disable iff (reset)
      regs_ff[psg_pkg::REG_SHAPE][7:4] == 4'h0)
      else $error("shape register holds bits above the shape code");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("response word changed while stalled");
`endif

endmodule
`default_nettype wire

### hdl/psg_tone_envelope_generator.sv
`default_nettype none
// Path: tick word -> input register -> queue slot -> registered sample on rsp.
// Throughput: one request word per cycle while rsp_tready is not held low, set
// by the execute stage that updates counters, envelope and mixer together.
// Reset: synchronous; clears registers, counters, envelope and queue, and
// loads the step with 7. No clearing pass; the block is ready at once.
// ---------------------------------------------------------------------------
// psg_tone_envelope_generator: three-voice tone and envelope sound generator
// Input stage, item queue and execution stage with a registered output.
// ---------------------------------------------------------------------------
module psg_tone_envelope_generator (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,    // [3:0] reg_index, [11:4] reg_value
   input  wire  [0:0]  req_tuser,    // [0] req_type
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,    // [7:0] amp_a, [15:8] amp_b, [23:16] amp_c
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [7:0]  csr_data      // step_per_sample
);

   psg_pkg::queue_status_type q_status;
   psg_pkg::item_type         push_item;
   psg_pkg::item_type         pop_item;
   logic                      push;
   logic                      pop;

   psg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .push       (push),
      .push_item  (push_item)
   );

   psg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_status  (q_status)
   );

   psg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .q_status   (q_status),
      .pop_item   (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire
